// ===== hw/rtl/alr_pkg.sv =====
// ----------------------------------------------------------------------------
// alr_pkg
// Shared types and constants for the audio loop recorder and player: item
// op codes, configuration register indexes, status flags and reset values.
// ----------------------------------------------------------------------------
package alr_pkg;

  // default sizing of the loop memory and sample words
  localparam int MEM_DEPTH_DEF   = 65536;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int POS_BITS      = 17;
  localparam int FRAME_BITS    = 16;
  localparam int GAIN_BITS     = 16;
  localparam int FRAC_BITS     = 12;
  localparam int OP_BITS       = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 17;

  // register reset values
  localparam logic [POS_BITS-1:0]   LOOP_LENGTH_RST = 17'd65536;
  localparam logic [FRAME_BITS-1:0] START_FRAME_RST = 16'd0;
  localparam logic [POS_BITS-1:0]   END_FRAME_RST   = 17'd65536;
  localparam logic                  LOOP_PLAY_RST   = 1'b1;
  localparam logic                  LOOP_REC_RST    = 1'b0;

  // item op codes
  typedef enum logic [OP_BITS-1:0] {
    OP_SAMPLE    = 3'd0,
    OP_RESET_POS = 3'd1,
    OP_PLAY      = 3'd2,
    OP_RECORD    = 3'd3,
    OP_SET_POS   = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LOOP_LENGTH = 3'd0,
    CFG_START_FRAME = 3'd1,
    CFG_END_FRAME   = 3'd2,
    CFG_LOOP_PLAY   = 3'd3,
    CFG_LOOP_REC    = 3'd4
  } cfg_idx_t;

  // status flags carried with each result
  typedef struct packed {
    logic playing;
    logic recording;
    logic stopped;
  } status_t;

endpackage

// ===== hw/rtl/alr_ram.sv =====
// ----------------------------------------------------------------------------
// alr_ram
// Generic single-port RAM with one write or read per cycle and a registered
// read (read-first on a write to the same address).
// ----------------------------------------------------------------------------
module alr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/alr_mac.sv =====
// ----------------------------------------------------------------------------
// alr_mac
// Sample times Q3.12 gain (when use_prod is set) plus an addend, rounded half
// up to the sample grid and saturated to the signed sample range.
// ----------------------------------------------------------------------------
module alr_mac #(
  parameter int SAMPLE_BITS = alr_pkg::SAMPLE_BITS_DEF
) (
  input  logic signed [SAMPLE_BITS-1:0]                    smp,
  input  logic signed [alr_pkg::GAIN_BITS-1:0]             gain,
  input  logic                                             use_prod,
  input  logic signed [SAMPLE_BITS+alr_pkg::GAIN_BITS-1:0] addend,
  output logic signed [SAMPLE_BITS-1:0]                    result
);
  import alr_pkg::*;

  localparam int PW = SAMPLE_BITS + GAIN_BITS;
  localparam int AW = PW + 2;
  localparam logic signed [AW-1:0] HALF   = AW'(1 <<< (FRAC_BITS - 1));
  localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic signed [AW-1:0] scaled;

  // product, sum and rounding offset (signed zero keeps the product signed)
  assign prod   = use_prod ? smp * gain : PW'(0);
  assign acc    = {{2{prod[PW-1]}}, prod} + {{2{addend[PW-1]}}, addend} + HALF;
  assign scaled = acc >>> FRAC_BITS;

  // clamp to the sample range
  always_comb begin
    if (scaled > SAT_HI) begin
      result = SAT_HI[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_LO) begin
      result = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      result = scaled[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== hw/rtl/audio_loop_recorder_player.sv =====
// ----------------------------------------------------------------------------
// audio_loop_recorder_player
// Mono looper: mixes live input with the stored loop and overdubs the loop
// memory with feedback, one result per item.
// ----------------------------------------------------------------------------
// A result passes the stage 1 registers, then the output or skid register.
// A sample item holds the single memory port (play read, record read, record
//   write) and blocks new items meanwhile; control items go one per cycle
//   while the output is not stalled. Reset: loads the config reset values,
//   clears loop state, then zeroes memory with in_ready low (config still taken).
// ----------------------------------------------------------------------------
module audio_loop_recorder_player #(
  parameter int MEM_DEPTH   = alr_pkg::MEM_DEPTH_DEF,
  parameter int SAMPLE_BITS = alr_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [alr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [alr_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [alr_pkg::OP_BITS-1:0]           op,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in,
  input  logic signed [alr_pkg::GAIN_BITS-1:0]  feedback_gain,
  input  logic signed [alr_pkg::GAIN_BITS-1:0]  through_gain,
  input  logic signed [alr_pkg::GAIN_BITS-1:0]  loop_gain,
  input  logic [alr_pkg::FRAME_BITS-1:0]        position,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         sample_out,
  output logic                                  playing,
  output logic                                  recording,
  output logic                                  stopped
);
  import alr_pkg::*;

  localparam int AW   = $clog2(MEM_DEPTH);
  localparam int PW   = SAMPLE_BITS + GAIN_BITS;
  localparam int LENW = (POS_BITS > AW + 1) ? POS_BITS : AW + 1;
  localparam logic [LENW-1:0] DEPTH_L = LENW'(MEM_DEPTH);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(MEM_DEPTH - 1);

  // configuration registers
  logic [POS_BITS-1:0]   loop_length;
  logic [FRAME_BITS-1:0] start_frame;
  logic [POS_BITS-1:0]   end_frame;
  logic                  loop_play;
  logic                  loop_rec;

  // loop state
  logic [POS_BITS-1:0] play_pos, play_pos_next;
  logic [POS_BITS-1:0] rec_pos, rec_pos_next;
  logic                play_on, play_on_next;
  logic                rec_on, rec_on_next;
  logic                halted, halted_next;

  // clearing pass
  logic          clr_busy;
  logic [AW-1:0] clr_addr;

  // stage 1: play data returns, mix
  logic                   s1_valid;
  logic                   s1_sample;
  logic                   s1_play_hit;
  logic                   s1_rec_hit;
  logic [AW-1:0]          s1_rec_addr;
  logic signed [SAMPLE_BITS-1:0] s1_x;
  logic signed [GAIN_BITS-1:0]   s1_fb;
  logic signed [GAIN_BITS-1:0]   s1_lg;
  logic signed [PW-1:0]   s1_thru;
  status_t                s1_status;

  // stage 2: record data returns, overdub write
  logic                   s2_valid;
  logic                   s2_we;
  logic [AW-1:0]          s2_addr;
  logic signed [SAMPLE_BITS-1:0] s2_x;
  logic signed [GAIN_BITS-1:0]   s2_fb;

  // output and skid registers
  logic                          hold_valid;
  logic signed [SAMPLE_BITS-1:0] hold_sample;
  status_t                       hold_status;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  status_t                       out_status;

  // memory port
  logic                   ram_we;
  logic [AW-1:0]          ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic                          accept;
  logic                          take;
  logic [LENW-1:0]               len;
  logic [POS_BITS-1:0]           pp_inc;
  logic [POS_BITS-1:0]           rp_inc;
  logic                          play_hit;
  logic                          rec_hit;
  logic signed [SAMPLE_BITS-1:0] mix_result;
  logic signed [SAMPLE_BITS-1:0] res_sample;
  logic signed [SAMPLE_BITS-1:0] ovd_result;
  logic signed [PW-1:0]          ovd_addend;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign take      = out_valid && out_ready;

  // block new items while the memory port or the result path is taken
  assign in_ready = !clr_busy && !hold_valid && !s2_valid && !(s1_valid && s1_sample) &&
                    !(s1_valid && out_valid && !out_ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length <= LOOP_LENGTH_RST;
      start_frame <= START_FRAME_RST;
      end_frame   <= END_FRAME_RST;
      loop_play   <= LOOP_PLAY_RST;
      loop_rec    <= LOOP_REC_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LOOP_LENGTH: loop_length <= cfg_data;
        CFG_START_FRAME: start_frame <= cfg_data[FRAME_BITS-1:0];
        CFG_END_FRAME:   end_frame   <= cfg_data;
        CFG_LOOP_PLAY:   loop_play   <= cfg_data[0];
        CFG_LOOP_REC:    loop_rec    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // loop length clipped to the memory
  assign len      = (LENW'(loop_length) > DEPTH_L) ? DEPTH_L : LENW'(loop_length);
  assign pp_inc   = play_pos + 1'b1;
  assign rp_inc   = rec_pos + 1'b1;
  assign play_hit = play_on && (LENW'(play_pos) < len);
  assign rec_hit  = rec_on && (LENW'(rec_pos) < len);

  // position and flag update on each transfer
  always_comb begin
    play_pos_next = play_pos;
    rec_pos_next  = rec_pos;
    play_on_next  = play_on;
    rec_on_next   = rec_on;
    halted_next   = halted;
    if (accept) begin
      case (op_t'(op))
        OP_SAMPLE: begin
          play_pos_next = pp_inc;
          rec_pos_next  = rp_inc;
          if (pp_inc >= end_frame) begin
            if (loop_play) begin
              play_pos_next = {1'b0, start_frame};
            end else begin
              play_on_next = 1'b0;
              if (!rec_on) halted_next = 1'b1;
            end
          end
          if (LENW'(rp_inc) >= len) begin
            if (loop_rec) begin
              rec_pos_next = '0;
            end else begin
              rec_on_next = 1'b0;
              if (!play_on_next) halted_next = 1'b1;
            end
          end
        end
        OP_RESET_POS: play_pos_next = {1'b0, start_frame};
        OP_PLAY: begin
          play_pos_next = {1'b0, start_frame};
          play_on_next  = 1'b1;
          halted_next   = 1'b0;
        end
        OP_RECORD: begin
          rec_pos_next = '0;
          rec_on_next  = 1'b1;
          halted_next  = 1'b0;
        end
        OP_SET_POS: play_pos_next = {1'b0, position};
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      play_pos <= '0;
      rec_pos  <= '0;
      play_on  <= 1'b0;
      rec_on   <= 1'b0;
      halted   <= 1'b0;
    end else begin
      play_pos <= play_pos_next;
      rec_pos  <= rec_pos_next;
      play_on  <= play_on_next;
      rec_on   <= rec_on_next;
      halted   <= halted_next;
    end
  end

  // memory sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == LAST_ADDR) clr_busy <= 1'b0;
    end
  end

  // memory port schedule: sweep, overdub write, record read, play read
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = AW'(play_pos);
    ram_wdata = ovd_result;
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_addr  = clr_addr;
      ram_wdata = '0;
    end else if (s2_valid) begin
      ram_we   = s2_we;
      ram_addr = s2_addr;
    end else if (s1_valid && s1_sample) begin
      ram_addr = s1_rec_addr;
    end
  end

  alr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // stage 1 capture at transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample   <= (op_t'(op) == OP_SAMPLE);
      s1_play_hit <= play_hit;
      s1_rec_hit  <= rec_hit;
      s1_rec_addr <= AW'(rec_pos);
      s1_x        <= sample_in;
      s1_fb       <= feedback_gain;
      s1_lg       <= loop_gain;
      s1_thru     <= sample_in * through_gain;
      s1_status   <= '{playing: play_on_next, recording: rec_on_next, stopped: halted_next};
    end
  end

  // output mix from the played sample
  alr_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mix (
    .smp      ($signed(ram_rdata)),
    .gain     (s1_lg),
    .use_prod (s1_play_hit),
    .addend   (s1_thru),
    .result   (mix_result)
  );

  assign res_sample = s1_sample ? mix_result : '0;

  // stage 2 capture for sample items
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_sample) begin
      s2_we   <= s1_rec_hit;
      s2_addr <= s1_rec_addr;
      s2_x    <= s1_x;
      s2_fb   <= s1_fb;
    end
  end

  // overdub: feedback on old sample plus live input
  assign ovd_addend = {{(GAIN_BITS - FRAC_BITS){s2_x[SAMPLE_BITS-1]}}, s2_x,
                       {FRAC_BITS{1'b0}}};

  alr_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ovd (
    .smp      ($signed(ram_rdata)),
    .gain     (s2_fb),
    .use_prod (1'b1),
    .addend   (ovd_addend),
    .result   (ovd_result)
  );

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (hold_valid && take) begin
      out_valid  <= 1'b1;
      hold_valid <= 1'b0;
    end else if (s1_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        hold_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_valid && take) begin
      out_sample <= hold_sample;
      out_status <= hold_status;
    end else if (s1_valid) begin
      if (!out_valid || take) begin
        out_sample <= res_sample;
        out_status <= s1_status;
      end else begin
        hold_sample <= res_sample;
        hold_status <= s1_status;
      end
    end
  end

  assign sample_out = out_sample;
  assign playing    = out_status.playing;
  assign recording  = out_status.recording;
  assign stopped    = out_status.stopped;

  // the memory port never writes in a cycle that takes a play read
  a_no_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !ram_we)
    else $error("memory write collides with play read");

  // a new result never meets a full skid entry
  a_no_skid_overrun: assert property (@(posedge clk) disable iff (rst)
    !(hold_valid && s1_valid))
    else $error("result arrives while skid entry is full");

  // a sample item keeps the port for its record read and write
  a_sample_spacing: assert property (@(posedge clk) disable iff (rst)
    (accept && op_t'(op) == OP_SAMPLE) |=> !in_ready ##1 !in_ready)
    else $error("item taken inside a sample item's memory slots");

  // no items while the memory is swept
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready)
    else $error("item taken during memory clear");

endmodule
